@@ hdl/hss_pkg.sv @@
// Shared types, codes and helpers for the homing stall sequencer.
package hss_pkg;

   // Command codes carried by each input transaction
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_CANCEL = 2'd2;
   localparam logic [1:0] CMD_EXPIRY = 2'd3;

   // Mode codes, also reported as status
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_SEEK  = 3'd1;
   localparam logic [2:0] MODE_BACK  = 3'd2;
   localparam logic [2:0] MODE_HOMED = 3'd3;
   localparam logic [2:0] MODE_FAIL  = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] REG_HOMING_MV        = 3'd0;
   localparam logic [2:0] REG_BACKOFF_MV       = 3'd1;
   localparam logic [2:0] REG_BACKOFF_TIME_MS  = 3'd2;
   localparam logic [2:0] REG_RUN_TIMEOUT_MS   = 3'd3;
   localparam logic [2:0] REG_CURRENT_LIMIT_MA = 3'd4;
   localparam logic [2:0] REG_CURRENT_HOLD_MS  = 3'd5;
   localparam logic [2:0] REG_SPEED_LIMIT_RPM  = 3'd6;
   localparam logic [2:0] REG_STALL_HOLD_MS    = 3'd7;

   typedef struct packed {
      logic signed [15:0] homing_mv;
      logic [14:0]        backoff_mv;
      logic [15:0]        backoff_time_ms;
      logic [15:0]        run_timeout_ms;
      logic [15:0]        current_limit_ma;
      logic [15:0]        current_hold_ms;
      logic [14:0]        speed_limit_rpm;
      logic [15:0]        stall_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] run_elapsed;
      logic [15:0] phase_elapsed;
      logic [15:0] overcurrent_elapsed;
      logic [15:0] stall_elapsed;
      logic        overcurrent_active;
      logic        stall_active;
      logic        seen_moving;
   } state_type;

   typedef struct packed {
      logic               drive_write;
      logic signed [15:0] drive_mv;
      logic               zero_pulse;
      logic [2:0]         status;
   } result_type;

   // Saturating millisecond counter increment
   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

@@ hdl/hss_step.sv @@
// Next-state and result logic for one transaction of the homing sequencer.
module hss_step #(
   parameter int GRACE_MS = 100
) (
   input  hss_pkg::cfg_type    cfg,
   input  hss_pkg::state_type  st,
   input  logic [1:0]          command,
   input  logic                limit_pressed,
   input  logic [15:0]         current_ma,
   input  logic signed [15:0]  velocity_rpm,
   output hss_pkg::state_type  nxt,
   output hss_pkg::result_type res
);
   import hss_pkg::*;

   localparam logic [15:0] GraceLim = 16'(GRACE_MS);

   logic        homing;
   logic [15:0] run_i;
   logic [15:0] phase_i;
   logic        grace_done;
   logic [15:0] speed;
   logic [15:0] oc_el;
   logic [15:0] st_el;
   logic        stop;
   logic [2:0]  target;
   logic signed [15:0] backoff_neg;

   always_comb begin
      homing      = (st.mode == MODE_SEEK) || (st.mode == MODE_BACK);
      run_i       = sat_inc(st.run_elapsed);
      phase_i     = sat_inc(st.phase_elapsed);
      grace_done  = run_i >= GraceLim;
      speed       = velocity_rpm[15] ? 16'(-velocity_rpm) : 16'(velocity_rpm);
      backoff_neg = 16'(16'd0 - {1'b0, cfg.backoff_mv});
      oc_el       = 16'd0;
      st_el       = 16'd0;
      stop        = 1'b0;
      target      = st.mode;
      nxt         = st;
      res         = '0;

      unique case (command)
         CMD_START: begin
            nxt        = '0;
            nxt.mode   = MODE_SEEK;
            target     = MODE_SEEK;
         end
         CMD_CANCEL: begin
            if (homing) begin
               res.drive_write = 1'b1;
               target          = MODE_IDLE;
            end
         end
         CMD_EXPIRY: begin
            res.drive_write = 1'b1;
            if (homing) target = MODE_FAIL;
         end
         default: begin
            if (homing) begin
               nxt.run_elapsed   = run_i;
               nxt.phase_elapsed = phase_i;
               res.drive_write   = 1'b1;
               if (st.mode == MODE_SEEK) begin
                  if (cfg.run_timeout_ms != 16'd0 && run_i >= cfg.run_timeout_ms) begin
                     target = MODE_FAIL;
                  end else begin
                     res.drive_mv = cfg.homing_mv;
                     // limit switch stops at once
                     if (limit_pressed) stop = 1'b1;
                     // over-current dwell after the startup grace
                     if (!stop && cfg.current_limit_ma != 16'd0) begin
                        if (current_ma < cfg.current_limit_ma || !grace_done) begin
                           nxt.overcurrent_active  = 1'b0;
                           nxt.overcurrent_elapsed = 16'd0;
                        end else begin
                           oc_el = st.overcurrent_active ?
                                   sat_inc(st.overcurrent_elapsed) : 16'd0;
                           nxt.overcurrent_active  = 1'b1;
                           nxt.overcurrent_elapsed = oc_el;
                           if (oc_el >= cfg.current_hold_ms) stop = 1'b1;
                        end
                     end
                     // stall dwell once moving or past grace
                     if (!stop && cfg.speed_limit_rpm != 15'd0) begin
                        if (speed >= {1'b0, cfg.speed_limit_rpm}) begin
                           nxt.seen_moving   = 1'b1;
                           nxt.stall_active  = 1'b0;
                           nxt.stall_elapsed = 16'd0;
                        end else if (st.seen_moving || grace_done) begin
                           st_el = st.stall_active ? sat_inc(st.stall_elapsed) : 16'd0;
                           nxt.stall_active  = 1'b1;
                           nxt.stall_elapsed = st_el;
                           if (st_el >= cfg.stall_hold_ms) stop = 1'b1;
                        end
                     end
                     if (stop) begin
                        res.drive_mv   = 16'sd0;
                        res.zero_pulse = 1'b1;
                        if (cfg.backoff_time_ms != 16'd0 && cfg.backoff_mv != 15'd0)
                           target = MODE_BACK;
                        else
                           target = MODE_HOMED;
                     end
                  end
               end else begin
                  // back off at the opposite sign until the time runs out
                  if (phase_i >= cfg.backoff_time_ms) begin
                     target = MODE_HOMED;
                  end else if (cfg.homing_mv[15]) begin
                     res.drive_mv = 16'({1'b0, cfg.backoff_mv});
                  end else begin
                     res.drive_mv = backoff_neg;
                  end
               end
            end
         end
      endcase

      // clear phase timers on a change of mode
      if (target != st.mode) begin
         nxt.mode                = target;
         nxt.phase_elapsed       = 16'd0;
         nxt.overcurrent_elapsed = 16'd0;
         nxt.stall_elapsed       = 16'd0;
         nxt.overcurrent_active  = 1'b0;
         nxt.stall_active        = 1'b0;
      end
      res.status = nxt.mode;
   end

endmodule

@@ hdl/homing_stall_sequencer.sv @@
// Top level of the motor homing sequencer with stall and over-current detection.
// Each accepted request's response is registered in the output or the skid register.
// Throughput: one transaction per cycle unless stalled; single-pass step logic.
// A skid register holds one response while the output side stalls.
// Reset (synchronous, active high) clears mode, timers, flags and all
// configuration registers, and empties the output stage.
module homing_stall_sequencer #(
   parameter int GRACE_MS = 100
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic               req_limit_pressed,
   input  logic [15:0]        req_current_ma,
   input  logic signed [15:0] req_velocity_rpm,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_drive_write,
   output logic signed [15:0] rsp_drive_mv,
   output logic               rsp_zero_pulse,
   output logic [2:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import hss_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type step_res;
   result_type out_ff;
   result_type skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       req_take;
   logic       rsp_take;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   hss_step #(
      .GRACE_MS(GRACE_MS)
   ) u_step (
      .cfg           (cfg_ff),
      .st            (state_ff),
      .command       (req_command),
      .limit_pressed (req_limit_pressed),
      .current_ma    (req_current_ma),
      .velocity_rpm  (req_velocity_rpm),
      .nxt           (state_in),
      .res           (step_res)
   );

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_HOMING_MV:        cfg_ff.homing_mv        <= csr_data;
            REG_BACKOFF_MV:       cfg_ff.backoff_mv       <= csr_data[14:0];
            REG_BACKOFF_TIME_MS:  cfg_ff.backoff_time_ms  <= csr_data;
            REG_RUN_TIMEOUT_MS:   cfg_ff.run_timeout_ms   <= csr_data;
            REG_CURRENT_LIMIT_MA: cfg_ff.current_limit_ma <= csr_data;
            REG_CURRENT_HOLD_MS:  cfg_ff.current_hold_ms  <= csr_data;
            REG_SPEED_LIMIT_RPM:  cfg_ff.speed_limit_rpm  <= csr_data[14:0];
            REG_STALL_HOLD_MS:    cfg_ff.stall_hold_ms    <= csr_data;
            default:              cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   // Advance sequencer state on each accepted transaction; all zero is idle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // Hold valid flags of the output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) skid_valid_ff <= 1'b0;
      end else if (req_take) begin
         if (out_valid_ff && rsp_stall) skid_valid_ff <= 1'b1;
         else                           out_valid_ff  <= 1'b1;
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Load response payloads
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) out_ff <= skid_ff;
      end else if (req_take) begin
         if (out_valid_ff && rsp_stall) skid_ff <= step_res;
         else                           out_ff  <= step_res;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_drive_write = out_ff.drive_write;
   assign rsp_drive_mv    = out_ff.drive_mv;
   assign rsp_zero_pulse  = out_ff.zero_pulse;
   assign rsp_status      = out_ff.status;

endmodule
